// File: rtl/c_subset_lexer_classifier_assert.svh
// ---------------------------------------------------------------------------
// c_subset_lexer_classifier assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef C_SUBSET_LEXER_CLASSIFIER_ASSERT_SVH
`define C_SUBSET_LEXER_CLASSIFIER_ASSERT_SVH

`ifndef SYNTH
`define CLX_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lexer assertion failed");
`define CLX_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("lexer forbidden condition seen");
`else
`define CLX_ASSERT(lbl, prop)
`define CLX_ASSERT_NEVER(lbl, cond)
`endif

`endif

// File: rtl/c_lex_pkg.sv
// ---------------------------------------------------------------------------
// c_lex_pkg
// shared types, keyword tables and character codes of the lexer
// ---------------------------------------------------------------------------
package c_lex_pkg;

  localparam int unsigned MaxTokenLengthDefault = 255;
  localparam int unsigned LineCountBitsDefault  = 16;

  localparam int unsigned NumKw   = 7;
  localparam int unsigned KwSlots = 8;

  // keyword text, zero padded
  localparam logic [7:0] KW_TEXT [NumKw][KwSlots] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"m", "a", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"c", "o", "u", "t", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
    '{"d", "o", "u", "b", "l", "e", 8'h00, 8'h00},
    '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [NumKw] = '{3'd3, 3'd4, 3'd6, 3'd4, 3'd5, 3'd6, 3'd4};

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChLBrace = 8'h7b;
  localparam logic [7:0] ChRBrace = 8'h7d;
  localparam logic [7:0] ChSemi   = 8'h3b;
  localparam logic [7:0] ChEq     = 8'h3d;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChStar   = 8'h2a;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  typedef enum logic [2:0] {
    TOK_KEYWORD  = 3'd0,
    TOK_CONSTANT = 3'd1,
    TOK_IDENT    = 3'd2,
    TOK_PUNCT    = 3'd3,
    TOK_OPERATOR = 3'd4,
    TOK_STRING   = 3'd5
  } token_class_e;

  typedef struct packed {
    token_class_e cls;
    logic [7:0]   len;
    logic [7:0]   sym;
    logic [15:0]  line;
    logic         last;
  } res_t;

  // up to two results produced by one item
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic [FifoCntW-1:0] count;
    logic                room2;
  } fifo_status_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == ChLParen) || (c == ChRParen) || (c == ChLBrace) ||
           (c == ChRBrace) || (c == ChSemi);
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == ChEq) || (c == ChPlus) || (c == ChMinus) ||
           (c == ChStar) || (c == ChSlash);
  endfunction

endpackage

// File: rtl/c_lex_core.sv
// ---------------------------------------------------------------------------
// c_lex_core
// per-character token state update and result formation
// ---------------------------------------------------------------------------
module c_lex_core #(
  parameter int unsigned MAX_TOKEN_LENGTH = c_lex_pkg::MaxTokenLengthDefault,
  parameter int unsigned LINE_COUNT_BITS  = c_lex_pkg::LineCountBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        char_i,
  input  logic              eol_i,
  output c_lex_pkg::push_t  push_o
);
  import c_lex_pkg::*;

  localparam int unsigned LenW      = $clog2(MAX_TOKEN_LENGTH + 1);
  localparam int unsigned OutLenMax = (MAX_TOKEN_LENGTH > 255) ? 255 : MAX_TOKEN_LENGTH;

  logic [LenW-1:0]            word_len_q, word_len_d;
  logic                       word_digit_q, word_digit_d;
  logic [NumKw-1:0]           kw_match_q, kw_match_d;
  logic                       in_str_q, in_str_d;
  logic [LenW-1:0]            str_len_q, str_len_d;
  logic [LINE_COUNT_BITS-1:0] line_q, line_d;

  logic                       kw_hit;
  logic [NumKw-1:0]           kw_keep;
  logic [31:0]                line_wide;
  logic [15:0]                line_out;
  res_t                       str_res, word_res, sym_res;
  logic                       str_v, word_v, sym_v;
  logic [1:0]                 n;

  always_comb begin
    kw_hit  = 1'b0;
    kw_keep = '0;
    for (int k = 0; k < NumKw; k++) begin
      if (kw_match_q[k] && (word_len_q == LenW'(KW_LEN[k]))) begin
        kw_hit = 1'b1;
      end
      kw_keep[k] = (word_len_q < LenW'(KW_LEN[k])) &&
                   (char_i == KW_TEXT[k][word_len_q[2:0]]);
    end

    line_wide = 32'(line_q);
    line_out  = (line_wide > 32'd65535) ? 16'hffff : line_wide[15:0];

    str_res.cls  = TOK_STRING;
    str_res.len  = (str_len_q > LenW'(OutLenMax)) ? 8'(OutLenMax) : 8'(str_len_q);
    str_res.sym  = '0;
    str_res.line = line_out;
    str_res.last = 1'b0;

    word_res.cls  = kw_hit ? TOK_KEYWORD : (word_digit_q ? TOK_CONSTANT : TOK_IDENT);
    word_res.len  = (word_len_q > LenW'(OutLenMax)) ? 8'(OutLenMax) : 8'(word_len_q);
    word_res.sym  = '0;
    word_res.line = line_out;
    word_res.last = 1'b0;

    sym_res.cls  = is_punct(char_i) ? TOK_PUNCT : TOK_OPERATOR;
    sym_res.len  = 8'd1;
    sym_res.sym  = char_i;
    sym_res.line = line_out;
    sym_res.last = 1'b0;

    word_len_d   = word_len_q;
    word_digit_d = word_digit_q;
    kw_match_d   = kw_match_q;
    in_str_d     = in_str_q;
    str_len_d    = str_len_q;
    line_d       = line_q;
    str_v        = 1'b0;
    word_v       = 1'b0;
    sym_v        = 1'b0;

    if (step_i) begin
      if (eol_i) begin
        // string first, then word, then next line
        if (in_str_q) begin
          str_v     = 1'b1;
          in_str_d  = 1'b0;
          str_len_d = '0;
        end
        if (word_len_q != '0) begin
          word_v = 1'b1;
        end
        if (line_q != '1) begin
          line_d = line_q + 1'b1;
        end
      end else if (in_str_q) begin
        if (char_i == ChQuote) begin
          str_v     = 1'b1;
          in_str_d  = 1'b0;
          str_len_d = '0;
        end else if (str_len_q < LenW'(MAX_TOKEN_LENGTH)) begin
          str_len_d = str_len_q + 1'b1;
        end
      end else if (char_i == ChQuote) begin
        // quote opens a string but leaves the word pending
        in_str_d  = 1'b1;
        str_len_d = '0;
      end else if (is_space(char_i) || is_punct(char_i)) begin
        word_v = (word_len_q != '0);
        sym_v  = is_punct(char_i);
      end else if (is_op(char_i)) begin
        sym_v = 1'b1;
      end else begin
        kw_match_d = kw_match_q & kw_keep;
        if (word_len_q == '0) begin
          word_digit_d = (char_i >= ChZero) && (char_i <= ChNine);
        end
        if (word_len_q < LenW'(MAX_TOKEN_LENGTH)) begin
          word_len_d = word_len_q + 1'b1;
        end
      end
      if (word_v) begin
        word_len_d   = '0;
        word_digit_d = 1'b0;
        kw_match_d   = '1;
      end
    end

    n = {1'b0, str_v} + {1'b0, word_v} + {1'b0, sym_v};

    push_o.n       = n;
    push_o.r0      = str_v ? str_res : (word_v ? word_res : sym_res);
    push_o.r1      = (str_v && word_v) ? word_res : sym_res;
    push_o.r0.last = (n == 2'd1);
    push_o.r1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_len_q   <= '0;
      word_digit_q <= 1'b0;
      kw_match_q   <= '1;
      in_str_q     <= 1'b0;
      str_len_q    <= '0;
      line_q       <= LINE_COUNT_BITS'(1);
    end else begin
      word_len_q   <= word_len_d;
      word_digit_q <= word_digit_d;
      kw_match_q   <= kw_match_d;
      in_str_q     <= in_str_d;
      str_len_q    <= str_len_d;
      line_q       <= line_d;
    end
  end

endmodule

// File: rtl/c_lex_fifo.sv
// ---------------------------------------------------------------------------
// c_lex_fifo
// result queue taking up to two results per cycle, one out per cycle
// ---------------------------------------------------------------------------
module c_lex_fifo (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  c_lex_pkg::push_t         push_i,
  input  logic                     pop_i,
  output c_lex_pkg::res_t          head_o,
  output c_lex_pkg::fifo_status_t  status_o
);
  import c_lex_pkg::*;

  res_t                mem [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic [FifoPtrW-1:0] wr_ptr_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_q + 1'b1;
    wr_ptr_d   = wr_ptr_q + FifoPtrW'(push_i.n);
    rd_ptr_d   = rd_ptr_q + FifoPtrW'(pop_i);
    cnt_d      = cnt_q + FifoCntW'(push_i.n) - FifoCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem[wr_ptr_nxt] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign head_o         = mem[rd_ptr_q];
  assign status_o.count = cnt_q;
  assign status_o.room2 = (cnt_q <= FifoCntW'(FifoDepth - 2));

endmodule

// File: rtl/c_subset_lexer_classifier.sv
// ---------------------------------------------------------------------------
// c_subset_lexer_classifier
// token classifier for a small c subset, one source byte per transfer
// ---------------------------------------------------------------------------
// slave channel: one source byte per transfer in tdata, tuser high marks an
//   end-of-line item (its byte is ignored); end of line flushes an open
//   string, then a pending word, then advances the line count
// master channel: one token per transfer, class in tuser, length, symbol and
//   line in tdata, tlast high on the final token caused by an input item;
//   an input item gives zero, one or two tokens
// path: an item's tokens are offered once the item has passed the input
//   register and been classified into the result queue; a stall can hold the
//   item in the input register between the two
// throughput: one item per cycle while items give at most one token each and
//   the master side takes the tokens offered; items giving two tokens are
//   absorbed by the four-entry result queue until it lacks room for two
// stall: the input register holds its item while the queue lacks room for
//   two tokens, and tready drops only then; no token is lost or repeated
// reset: rst_ni low clears the queue and token state, line count back to one
// ---------------------------------------------------------------------------
`include "c_subset_lexer_classifier_assert.svh"

module c_subset_lexer_classifier #(
  parameter int unsigned MAX_TOKEN_LENGTH = c_lex_pkg::MaxTokenLengthDefault,
  parameter int unsigned LINE_COUNT_BITS  = c_lex_pkg::LineCountBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] character
  input  logic        s_axis_tuser,   // [0] line_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] token_length, [15:8] token_symbol,
                                      // [31:16] line_number
  output logic [2:0]  m_axis_tuser,   // [2:0] token_class
  output logic        m_axis_tlast    // last
);
  import c_lex_pkg::*;

  // input register
  logic         in_valid_q, in_valid_d;
  logic [7:0]   in_char_q;
  logic         in_eol_q;
  logic         step;
  logic         pop;
  push_t        push;
  res_t         head;
  fifo_status_t fifo_st;

  // classify the held item only when the queue can take two tokens
  assign step          = in_valid_q && fifo_st.room2;
  assign s_axis_tready = !in_valid_q || fifo_st.room2;
  assign in_valid_d    = s_axis_tready ? s_axis_tvalid : in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_eol_q  <= s_axis_tuser;
    end
  end

  c_lex_core #(
    .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH),
    .LINE_COUNT_BITS  (LINE_COUNT_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .char_i (in_char_q),
    .eol_i  (in_eol_q),
    .push_o (push)
  );

  c_lex_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (fifo_st)
  );

  // output side straight from the queue head
  assign m_axis_tvalid = (fifo_st.count != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {head.line, head.sym, head.len};
  assign m_axis_tuser  = head.cls;
  assign m_axis_tlast  = head.last;

  // queue never overfills
  `CLX_ASSERT_NEVER(a_fifo_bound, fifo_st.count > FifoCntW'(FifoDepth))
  // a held item is not dropped while the queue lacks room for two tokens
  `CLX_ASSERT(a_item_held, (in_valid_q && !s_axis_tready) |=> in_valid_q)
  // tokens written to the queue are offered on the next cycle
  `CLX_ASSERT(a_push_visible, (push.n != 2'd0) |=> m_axis_tvalid)

endmodule
